### src/apdm_pkg.sv
// Shared types, constants and threshold arithmetic for the action potential duration meter
`default_nettype none

package apdm_pkg;

  // stream word widths, fields packed from bit 0 and padded to whole bytes
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 216;

  // field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned VoltW  = 16;
  localparam int unsigned SlopeW = 18;
  localparam int unsigned BeatW  = 16;
  localparam int unsigned RatioW = 16;

  // divider step counter width
  localparam int unsigned DivStepW = $clog2(RatioW);

  // pending result queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // slope maximum rearm value, -5000 V/s in 1/16 V/s
  localparam logic signed [SlopeW-1:0] SlopeRearm = -18'sd80000;

  // reciprocal of ten, 2^23 scale, exact for dividends below 2^22
  localparam logic [19:0] RecipTen = 20'd838861;

  // offset that makes the weighted sum non-negative, plus half of ten for rounding
  localparam logic signed [21:0] ThreshBias = 22'sd327685;

  // one finished measurement waiting for its ratio
  typedef struct packed {
    logic [BeatW-1:0]         beat;
    logic [TimeW-1:0]         start_time;
    logic signed [VoltW-1:0]  peak;
    logic signed [VoltW-1:0]  min_pot;
    logic signed [SlopeW-1:0] slope_max;
    logic [TimeW-1:0]         apd30;
    logic [TimeW-1:0]         apd50;
    logic [TimeW-1:0]         apd90;
  } job_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackDiv,
    BackOut
  } back_state_e;

  // point between lo and hi weighted (lo*w_lo + hi*w_hi)/10, nearest, ties upward
  function automatic logic signed [VoltW-1:0] apdm_thresh(
    input logic signed [VoltW-1:0] lo,
    input logic signed [VoltW-1:0] hi,
    input logic [3:0]              w_lo,
    input logic [3:0]              w_hi
  );
    logic signed [21:0] sum;
    logic signed [21:0] biased;
    logic [39:0]        prod;
    sum = 22'(lo) * $signed({18'd0, w_lo}) + 22'(hi) * $signed({18'd0, w_hi});
    biased = sum + ThreshBias;
    prod = 40'(biased[19:0]) * 40'(RecipTen);
    // quotient minus 32768 wraps to flipping the top bit
    return {~prod[38], prod[37:23]};
  endfunction

endpackage

`default_nettype wire

### src/apdm_front.sv
// Sample front end: minimum, upstroke, peak and threshold crossing detection
`default_nettype none

module apdm_front (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [0:0]                           cfg_wdata_i,
  input  wire                                  accept_i,
  input  wire  [apdm_pkg::TimeW-1:0]           sample_time_i,
  input  wire  signed [apdm_pkg::VoltW-1:0]    voltage_i,
  input  wire  signed [apdm_pkg::SlopeW-1:0]   slope_i,
  input  wire  [apdm_pkg::BeatW-1:0]           beat_number_i,
  output logic                                 push_o,
  output apdm_pkg::job_t                       job_o
);

  logic                               enable_q;
  logic signed [apdm_pkg::VoltW-1:0]  prev_v_q;
  logic signed [apdm_pkg::SlopeW-1:0] prev_s_q;
  logic signed [apdm_pkg::VoltW-1:0]  min_q, min_d;
  logic [apdm_pkg::TimeW-1:0]         cstart_q, cstart_d;
  logic signed [apdm_pkg::SlopeW-1:0] smax_q, smax_d, smax_base;
  logic [apdm_pkg::TimeW-1:0]         up_q, up_d;
  logic signed [apdm_pkg::VoltW-1:0]  peak_q, peak_d;
  logic signed [apdm_pkg::VoltW-1:0]  thr30_q, thr50_q, thr90_q;
  logic signed [apdm_pkg::VoltW-1:0]  thr30_d, thr50_d, thr90_d;
  logic signed [apdm_pkg::VoltW-1:0]  cand30_q, cand50_q, cand90_q;
  logic [apdm_pkg::TimeW-1:0]         d30_q, d30_d, d50_q, d50_d, d_now;
  logic                               min_hit, up_hit, meas, pk_hit;
  logic                               x30, x50, x90;

  // measurement enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i[0];
    end
  end

  // event detection and next measurement state
  always_comb begin
    min_hit   = enable_q && (prev_s_q < 0) && (slope_i >= 0);
    min_d     = min_hit ? prev_v_q : min_q;
    cstart_d  = min_hit ? sample_time_i : cstart_q;
    smax_base = min_hit ? apdm_pkg::SlopeRearm : smax_q;

    up_hit = enable_q && (slope_i > smax_base);
    smax_d = up_hit ? slope_i : smax_base;
    up_d   = up_hit ? sample_time_i : up_q;
    d_now  = sample_time_i - up_d;

    meas   = enable_q && (beat_number_i > apdm_pkg::BeatW'(1));
    pk_hit = meas && (prev_s_q > 0) && (slope_i <= 0);
    // thresholds for the peak at prev voltage were prepared on the last sample
    peak_d  = pk_hit ? prev_v_q : peak_q;
    thr30_d = pk_hit ? cand30_q : thr30_q;
    thr50_d = pk_hit ? cand50_q : thr50_q;
    thr90_d = pk_hit ? cand90_q : thr90_q;

    x30 = meas && (voltage_i <= thr30_d) && (prev_v_q > thr30_d);
    x50 = meas && (voltage_i <= thr50_d) && (prev_v_q > thr50_d);
    x90 = meas && (voltage_i <= thr90_d) && (prev_v_q > thr90_d);

    d30_d = x30 ? d_now : d30_q;
    d50_d = x50 ? d_now : d50_q;
  end

  // measurement state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_v_q <= '0;
      prev_s_q <= '0;
      min_q    <= '0;
      cstart_q <= '0;
      smax_q   <= apdm_pkg::SlopeRearm;
      up_q     <= '0;
      peak_q   <= '0;
      thr30_q  <= '0;
      thr50_q  <= '0;
      thr90_q  <= '0;
      cand30_q <= '0;
      cand50_q <= '0;
      cand90_q <= '0;
      d30_q    <= '0;
      d50_q    <= '0;
    end else if (accept_i) begin
      prev_v_q <= voltage_i;
      prev_s_q <= slope_i;
      min_q    <= min_d;
      cstart_q <= cstart_d;
      smax_q   <= smax_d;
      up_q     <= up_d;
      peak_q   <= peak_d;
      thr30_q  <= thr30_d;
      thr50_q  <= thr50_d;
      thr90_q  <= thr90_d;
      // candidate thresholds in case this sample turns out to be the peak
      cand30_q <= apdm_pkg::apdm_thresh(min_d, voltage_i, 4'd3, 4'd7);
      cand50_q <= apdm_pkg::apdm_thresh(min_d, voltage_i, 4'd5, 4'd5);
      cand90_q <= apdm_pkg::apdm_thresh(min_d, voltage_i, 4'd9, 4'd1);
      d30_q    <= d30_d;
      d50_q    <= d50_d;
    end
  end

  // finished measurement word towards the queue
  always_comb begin
    push_o            = accept_i && x90;
    job_o.beat        = beat_number_i;
    job_o.start_time  = cstart_d;
    job_o.peak        = peak_d;
    job_o.min_pot     = min_d;
    job_o.slope_max   = smax_d;
    job_o.apd30       = d30_d;
    job_o.apd50       = d50_d;
    job_o.apd90       = d_now;
  end

endmodule

`default_nettype wire

### src/apdm_fifo.sv
// Short queue of finished measurements between front and back
`default_nettype none

module apdm_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  apdm_pkg::job_t      job_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                valid_o,
  output apdm_pkg::job_t      job_o
);

  apdm_pkg::job_t                  mem_q [apdm_pkg::QueueDepth];
  logic [apdm_pkg::QueuePtrW-1:0]  wr_q, rd_q;
  logic [apdm_pkg::QueuePtrW:0]    cnt_q;

  // storage write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (apdm_pkg::QueuePtrW+1)'(push_i) - (apdm_pkg::QueuePtrW+1)'(pop_i);
    end
  end

  // status and head entry
  assign full_o  = (cnt_q == (apdm_pkg::QueuePtrW+1)'(apdm_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

endmodule

`default_nettype wire

### src/apdm_back.sv
// Back end: APD50/APD90 ratio by restoring division and the result register
`default_nettype none

module apdm_back (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 job_valid_i,
  input  apdm_pkg::job_t                      job_i,
  output logic                                pop_o,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [apdm_pkg::OutDataW-1:0]       m_axis_tdata
);

  apdm_pkg::back_state_e             state_q, state_d;
  apdm_pkg::job_t                    job_q, job_d;
  logic [apdm_pkg::TimeW-1:0]        rem_q, rem_d;
  logic [apdm_pkg::RatioW-1:0]       quo_q, quo_d;
  logic [apdm_pkg::DivStepW-1:0]     step_q, step_d;
  logic [apdm_pkg::TimeW:0]          rem2, diff;
  logic                              ge;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apdm_pkg::BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
  end

  // one quotient bit per cycle
  always_comb begin
    rem2 = {rem_q, 1'b0};
    diff = rem2 - {1'b0, job_q.apd90};
    ge   = !diff[apdm_pkg::TimeW];
  end

  // next state and outputs
  always_comb begin
    state_d       = state_q;
    job_d         = job_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    step_d        = step_q;
    pop_o         = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      apdm_pkg::BackIdle: begin
        if (job_valid_i) begin
          pop_o  = 1'b1;
          job_d  = job_i;
          rem_d  = job_i.apd50;
          quo_d  = '0;
          step_d = '0;
          // apd50 not below apd90 (or apd90 zero) saturates the ratio
          if (job_i.apd50 >= job_i.apd90) begin
            quo_d   = '1;
            state_d = apdm_pkg::BackOut;
          end else begin
            state_d = apdm_pkg::BackDiv;
          end
        end
      end
      apdm_pkg::BackDiv: begin
        rem_d  = ge ? diff[apdm_pkg::TimeW-1:0] : rem2[apdm_pkg::TimeW-1:0];
        quo_d  = {quo_q[apdm_pkg::RatioW-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == apdm_pkg::DivStepW'(apdm_pkg::RatioW - 1)) begin
          state_d = apdm_pkg::BackOut;
        end
      end
      apdm_pkg::BackOut: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d = apdm_pkg::BackIdle;
        end
      end
      default: begin
        state_d = apdm_pkg::BackIdle;
      end
    endcase
  end

  // result word
  assign m_axis_tdata = {6'd0, quo_q, job_q.apd90, job_q.apd50, job_q.apd30,
                         job_q.slope_max, job_q.min_pot, job_q.peak,
                         job_q.start_time, job_q.beat};

endmodule

`default_nettype wire

### src/action_potential_duration_meter.sv
// Top level of the action potential duration meter
// Takes one waveform sample per clock cycle on the input stream; the front
// end updates the minimum, upstroke, peak and threshold state for each
// accepted word. Each 90 percent repolarisation crossing produces one
// result word; its APD50/APD90 ratio comes from a bit-serial divider in the
// back end, which takes the next finished measurement only after the last
// result has been accepted on the output stream. Up to four finished
// measurements wait in a queue between the two ends; input is stalled only
// while that queue is full.
// measure_enable (reset 1) freezes the minimum, upstroke, peak, threshold
// and duration state when 0 (the previous sample still tracks); write it
// only while no result is pending.
`default_nettype none

module action_potential_duration_meter (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration: measure_enable
  input  wire                                  cfg_we_i,
  input  wire  [0:0]                           cfg_wdata_i,
  // samples
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_time[31:0], voltage[47:32], slope[65:48], beat_number[81:66]
  input  wire  [apdm_pkg::InDataW-1:0]         s_axis_tdata,
  // results
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // beat_out[15:0], cycle_start_time[47:16], peak_voltage[63:48],
  // min_diastolic_voltage[79:64], max_slope[97:80], apd30[129:98],
  // apd50[161:130], apd90[193:162], ratio_50_90[209:194]
  output logic [apdm_pkg::OutDataW-1:0]        m_axis_tdata
);

  logic           accept, push, full, pop, job_valid;
  apdm_pkg::job_t job_in, job_head;

  // input handshake
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  apdm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .sample_time_i (s_axis_tdata[31:0]),
    .voltage_i     ($signed(s_axis_tdata[47:32])),
    .slope_i       ($signed(s_axis_tdata[65:48])),
    .beat_number_i (s_axis_tdata[81:66]),
    .push_o        (push),
    .job_o         (job_in)
  );

  apdm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_head)
  );

  apdm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job_head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
